@@ design/lir_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  // Sample and position formats.
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 16;
  localparam int STEP_BITS    = 20;
  localparam int MAX_UPSAMPLE = 16;

  // The read position stays below one unit plus one step.
  localparam int POS_BITS = STEP_BITS + 1;
  localparam int CNT_BITS = $clog2(MAX_UPSAMPLE + 1);

  // Interpolation product: (SAMPLE_BITS + 1) signed times (FRAC_BITS + 1) signed.
  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + FRAC_BITS + 1;

  // Configuration register map.
  localparam int CFG_INDEX_BITS = 4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEREO = CFG_INDEX_BITS'(1);
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1 << FRAC_BITS);

  // Queue depths, both powers of two so that pointers wrap by themselves.
  localparam int JOBQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 4;

  // One run of interpolated outputs between two input frames.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] prev_left;
    logic signed [SAMPLE_BITS-1:0] prev_right;
    logic signed [SAMPLE_BITS-1:0] cur_left;
    logic signed [SAMPLE_BITS-1:0] cur_right;
    logic [FRAC_BITS-1:0]          start_pos;
    logic [CNT_BITS-1:0]           count;
  } job_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          last;
  } result_t;

endpackage

`default_nettype wire

@@ design/linear_interp_resampler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming linear-interpolation sample rate converter for mono or stereo
// Q1.23 audio frames. Each input frame that follows another frame of the same
// block produces every output whose read position falls between the two
// frames, computed as prev + (cur - prev) * frac with round-half-up, and the
// last output of that run carries last_of_run. The first frame of a block
// only primes the held frame, a frame whose interval is skipped by a large
// step produces nothing, and a frame with block_end set clears the held frame
// and the position. At most sixteen outputs come from one frame. The front
// end holds full high while it walks the read position one step per cycle
// to find the run length and until it hands the run over; a frame that
// produces no output does not raise full. The back end produces one output
// per cycle while the result queue has room, through a registered multiply
// stage, and rounds each result as it is written into the four-deep result
// queue. If the output side stalls long enough to fill that queue and the
// two-deep job queue, the front end cannot hand over its run and full stays
// high. Configuration writes are always taken
// (cfg_ready is tied high) and should be issued only while the block is idle;
// register 0 is the step (Q.16, input rate over output rate, reset 1.0) and
// register 1 selects stereo (reset on). In mono the right output is zero.

module linear_interp_resampler (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  // Input frames.
  input  wire logic                                        push,
  output logic                                             full,
  input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0]      sample_left,
  input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0]      sample_right,
  input  wire logic                                        block_end,
  // Output frames.
  output logic                                             empty,
  input  wire logic                                        pop,
  output logic signed [lir_pkg::SAMPLE_BITS-1:0]           out_left,
  output logic signed [lir_pkg::SAMPLE_BITS-1:0]           out_right,
  output logic                                             last_of_run,
  // Configuration writes.
  input  wire logic                                        cfg_valid,
  output logic                                             cfg_ready,
  input  wire logic [lir_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
  input  wire logic [lir_pkg::STEP_BITS-1:0]               cfg_data
);

  logic [lir_pkg::STEP_BITS-1:0] step;
  logic                          stereo;

  logic             fe_job_valid;
  logic             fe_job_ready;
  lir_pkg::job_t    fe_job;
  logic             be_job_valid;
  logic             be_job_ready;
  lir_pkg::job_t    be_job;
  lir_pkg::result_t result;

  // Step goes to both halves and stereo only to the back end. Writes to an
  // index outside the register map are accepted and dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= lir_pkg::STEP_RESET;
      stereo <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lir_pkg::REG_STEP) begin
        step <= cfg_data;
      end else if (cfg_index == lir_pkg::REG_STEREO) begin
        stereo <= cfg_data[0];
      end
    end
  end

  // The front end holds the previous frame and the read position and turns
  // each input transaction into at most one run description.
  lir_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .block_end    (block_end),
    .step         (step),
    .job_valid    (fe_job_valid),
    .job_ready    (fe_job_ready),
    .job          (fe_job)
  );

  // Runs wait here so that the front end can take the next frame while the
  // back end is still producing outputs.
  lir_job_queue u_job_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_job_valid),
    .in_ready  (fe_job_ready),
    .in_job    (fe_job),
    .out_valid (be_job_valid),
    .out_ready (be_job_ready),
    .out_job   (be_job)
  );

  // The back end queues one interpolated output per cycle while it has room.
  lir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (be_job_valid),
    .job_ready (be_job_ready),
    .job       (be_job),
    .step      (step),
    .stereo    (stereo),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign out_left    = result.left;
  assign out_right   = result.right;
  assign last_of_run = result.last;

endmodule

`default_nettype wire

@@ design/lir_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lir_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_left,
  input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] sample_right,
  input  wire logic                                  block_end,
  input  wire logic [lir_pkg::STEP_BITS-1:0]         step,
  output logic                                       job_valid,
  input  wire logic                                  job_ready,
  output lir_pkg::job_t                              job
);

  localparam logic [lir_pkg::POS_BITS-1:0] UNIT = lir_pkg::POS_BITS'(1 << lir_pkg::FRAC_BITS);
  localparam logic [lir_pkg::CNT_BITS-1:0] MAX_CNT =
    lir_pkg::CNT_BITS'(lir_pkg::MAX_UPSAMPLE);

  logic signed [lir_pkg::SAMPLE_BITS-1:0] prev_left;
  logic signed [lir_pkg::SAMPLE_BITS-1:0] prev_right;
  logic                                   have_prev;
  logic [lir_pkg::POS_BITS-1:0]           pos;
  logic                                   busy;
  logic [lir_pkg::POS_BITS-1:0]           scan;
  logic                                   run_end;
  lir_pkg::job_t                          run;

  logic accept;
  logic pos_below;
  logic scan_below;
  logic count_done;

  assign accept     = push && !busy;
  assign pos_below  = pos < UNIT;
  assign scan_below = scan < UNIT;
  assign count_done = !scan_below || (run.count == MAX_CNT);
  assign full       = busy;
  assign job_valid  = busy && count_done;
  assign job        = run;

  // The front walks the positions of a run only to learn its length and the
  // position left for the next frame; the back does the arithmetic.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      have_prev  <= 1'b0;
      pos        <= '0;
      prev_left  <= '0;
      prev_right <= '0;
    end else if (accept) begin
      prev_left  <= sample_left;
      prev_right <= sample_right;
      have_prev  <= !block_end;
      if (have_prev && pos_below) begin
        busy           <= 1'b1;
        run.prev_left  <= prev_left;
        run.prev_right <= prev_right;
        run.cur_left   <= sample_left;
        run.cur_right  <= sample_right;
        run.start_pos  <= pos[lir_pkg::FRAC_BITS-1:0];
        run.count      <= '0;
        scan           <= pos;
        run_end        <= block_end;
      end else if (block_end) begin
        pos <= '0;
      end else if (have_prev) begin
        pos <= pos - UNIT;
      end
    end else if (busy) begin
      if (!count_done) begin
        scan      <= scan + {1'b0, step};
        run.count <= run.count + 1'b1;
      end else if (job_ready) begin
        busy <= 1'b0;
        if (run_end || scan_below) begin
          pos <= '0;
        end else begin
          pos <= scan - UNIT;
        end
      end
    end
  end

  a_job_count: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (run.count != '0 && run.count <= MAX_CNT))
    else $error("run handed to the back with a bad output count");

endmodule

`default_nettype wire

@@ design/lir_job_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lir_job_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lir_pkg::job_t in_job,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lir_pkg::job_t      out_job
);

  localparam int PTR_BITS = $clog2(lir_pkg::JOBQ_DEPTH);
  localparam logic [PTR_BITS:0] DEPTH = (PTR_BITS + 1)'(lir_pkg::JOBQ_DEPTH);

  lir_pkg::job_t       slots [lir_pkg::JOBQ_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  logic do_push;
  logic do_pop;

  assign in_ready  = count != DEPTH;
  assign out_valid = count != '0;
  assign out_job   = slots[rd_ptr];
  assign do_push   = in_valid && in_ready;
  assign do_pop    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_jobq_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH)
    else $error("job queue occupancy out of range");

endmodule

`default_nettype wire

@@ design/lir_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lir_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_valid,
  output logic                               job_ready,
  input  wire lir_pkg::job_t                 job,
  input  wire logic [lir_pkg::STEP_BITS-1:0] step,
  input  wire logic                          stereo,
  output logic                               empty,
  input  wire logic                          pop,
  output lir_pkg::result_t                   result
);

  localparam int FB = lir_pkg::FRAC_BITS;
  localparam int SB = lir_pkg::SAMPLE_BITS;
  localparam int PB = lir_pkg::PROD_BITS;
  localparam int QP = $clog2(lir_pkg::OUTQ_DEPTH);
  localparam logic signed [PB-1:0] HALF = PB'(1 << (FB - 1));
  localparam logic [QP:0] QDEPTH = (QP + 1)'(lir_pkg::OUTQ_DEPTH);

  // Run registers.
  logic                                 active;
  logic signed [lir_pkg::DIFF_BITS-1:0] diff_left;
  logic signed [lir_pkg::DIFF_BITS-1:0] diff_right;
  logic signed [SB-1:0]                 base_left;
  logic signed [SB-1:0]                 base_right;
  logic [FB-1:0]                        frac;
  logic [lir_pkg::CNT_BITS-1:0]         left_cnt;

  // Product stage.
  logic                 st_valid;
  logic signed [PB-1:0] prod_left;
  logic signed [PB-1:0] prod_right;
  logic signed [SB-1:0] st_base_left;
  logic signed [SB-1:0] st_base_right;
  logic                 st_stereo;
  logic                 st_last;

  // Result queue.
  lir_pkg::result_t slots [lir_pkg::OUTQ_DEPTH];
  logic [QP-1:0]    wr_ptr;
  logic [QP-1:0]    rd_ptr;
  logic [QP:0]      count;

  logic             issue;
  logic             issue_last;
  logic             out_pop;
  logic signed [PB-1:0] round_left;
  logic signed [PB-1:0] round_right;
  lir_pkg::result_t res_new;

  // A result is issued only when the queue has room for it and for the one
  // still in the product stage.
  assign issue      = active && ((count + {{QP{1'b0}}, st_valid}) < QDEPTH);
  assign issue_last = issue && (left_cnt == lir_pkg::CNT_BITS'(1));
  assign job_ready  = !active || issue_last;
  assign out_pop    = pop && !empty;
  assign empty      = count == '0;
  assign result     = slots[rd_ptr];

  always_comb begin
    round_left    = (prod_left + HALF) >>> FB;
    round_right   = (prod_right + HALF) >>> FB;
    res_new.left  = st_base_left + round_left[SB-1:0];
    res_new.right = st_stereo ? (st_base_right + round_right[SB-1:0]) : '0;
    res_new.last  = st_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (job_valid && job_ready) begin
      active     <= 1'b1;
      diff_left  <= lir_pkg::DIFF_BITS'(job.cur_left) - lir_pkg::DIFF_BITS'(job.prev_left);
      diff_right <= lir_pkg::DIFF_BITS'(job.cur_right) - lir_pkg::DIFF_BITS'(job.prev_right);
      base_left  <= job.prev_left;
      base_right <= job.prev_right;
      frac       <= job.start_pos;
      left_cnt   <= job.count;
    end else if (issue) begin
      active   <= !issue_last;
      frac     <= frac + step[FB-1:0];
      left_cnt <= left_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= issue;
    end
    if (issue) begin
      prod_left     <= diff_left * $signed({1'b0, frac});
      prod_right    <= diff_right * $signed({1'b0, frac});
      st_base_left  <= base_left;
      st_base_right <= base_right;
      st_stereo     <= stereo;
      st_last       <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid) begin
      slots[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (st_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({st_valid, out_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    st_valid |-> (count != QDEPTH || out_pop))
    else $error("result queue written while full");

  a_active_count: assert property (@(posedge clk) disable iff (rst)
    active |-> left_cnt != '0)
    else $error("active run with no outputs left");

endmodule

`default_nettype wire

@@ tb/sv/linear_interp_resampler_test.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the streaming linear-interpolation resampler.
//
// Input frames go through the push/full port, and every accepted frame is run
// through a behavioral interpolator that mirrors the block's arithmetic. That
// interpolator appends the output frames that the input should produce to a
// queue. A separate process watches the empty/pop side and takes one entry off
// that queue for every output transaction, comparing all three fields.
//
// The run starts with short directed tests: reset defaults, full-scale swings,
// rounding ties, downsampling, tiny and zero steps that hit the sixteen-output
// cap, the largest step, mono operation and a stereo switch in the middle of a
// block, block-end handling, and writes to unused register indexes. After that,
// four random phases run with different handshake pacing. Each phase reprograms
// the step and channel mode every few dozen frames, and only while the block is
// idle.
module linear_interp_resampler_test;
  import lir_pkg::*;

  localparam int unsigned UNIT_POS = 1 << FRAC_BITS;
  localparam int CYCLE_LIMIT = 400000;
  // The slowest frame takes sixteen outputs plus the pipeline, so the settle
  // time covers a frame that is still in flight but produces nothing.
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int FRAMES_PER_SETTING = 32;

  // Indexes outside the register map. Writes to them must have no effect.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOP   = '1;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [STEP_BITS-1:0] STEP_TOP = '1;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic block_end;
  logic empty;
  logic pop;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic last_of_run;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [STEP_BITS-1:0] cfg_data;

  linear_interp_resampler u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample_left (sample_left),
    .sample_right(sample_right),
    .block_end   (block_end),
    .empty       (empty),
    .pop         (pop),
    .out_left    (out_left),
    .out_right   (out_right),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Bench copy of the configuration registers and the interpolator state.
  logic [STEP_BITS-1:0] model_step;
  logic model_stereo;
  logic signed [SAMPLE_BITS-1:0] held_left;
  logic signed [SAMPLE_BITS-1:0] held_right;
  int unsigned read_pos;
  bit holding;

  // Output frames that have been predicted but not yet popped, oldest first.
  result_t due_outputs[$];

  int send_idle_pct;
  int pop_stall_pct;
  int errors;
  int frames_sent;
  int outputs_seen;
  int reg_writes;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Returns prev + round_half_up((cur - prev) * frac / 2^FRAC_BITS). An
  // arithmetic shift floors the value, so adding half first gives round half up.
  function automatic logic signed [SAMPLE_BITS-1:0] interp_sample(
      input logic signed [SAMPLE_BITS-1:0] prev,
      input logic signed [SAMPLE_BITS-1:0] cur,
      input int unsigned frac);
    longint signed prod;
    longint signed q;
    prod = (longint'(cur) - longint'(prev)) * longint'(frac);
    q = (prod + longint'(UNIT_POS / 2)) >>> FRAC_BITS;
    return SAMPLE_BITS'(longint'(prev) + q);
  endfunction

  // Works out every output frame that one accepted input frame causes. One
  // output is produced for each read position below one unit, up to the cap.
  // After the run, one unit is taken off the position. If the run stopped at
  // the cap while still short of one unit, the rest of the interval is skipped.
  task automatic interpolate_frame(input logic signed [SAMPLE_BITS-1:0] cur_left,
                                   input logic signed [SAMPLE_BITS-1:0] cur_right,
                                   input logic frame_end);
    int n;
    result_t res;
    n = 0;
    if (holding) begin
      while (read_pos < UNIT_POS && n < MAX_UPSAMPLE) begin
        res.left = interp_sample(held_left, cur_left, read_pos);
        res.right = model_stereo ? interp_sample(held_right, cur_right, read_pos) : '0;
        n++;
        read_pos += model_step;
        res.last = (read_pos >= UNIT_POS) || (n == MAX_UPSAMPLE);
        due_outputs.insert(due_outputs.size(), res);
      end
      if (read_pos < UNIT_POS) read_pos = UNIT_POS;
      read_pos -= UNIT_POS;
    end
    held_left = cur_left;
    held_right = cur_right;
    holding = 1'b1;
    if (frame_end) begin
      holding = 1'b0;
      read_pos = 0;
    end
  endtask

  // Offers one frame and waits for its transaction. Random idle cycles are
  // placed before the frame, so push only drops when a gap is really taken.
  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                            input logic signed [SAMPLE_BITS-1:0] r,
                            input logic frame_end);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    sample_left <= l;
    sample_right <= r;
    block_end <= frame_end;
    do @(posedge clk); while (full);
    interpolate_frame(l, r, frame_end);
    frames_sent++;
  endtask

  // Holds the sender off until every predicted output has been popped. Then
  // it waits a bit longer, because a frame with no outputs may still be in the
  // front end at that point.
  task automatic wait_idle();
    push <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration transaction. The bench copy changes at the same edge.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [STEP_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_STEP) model_step = value;
    else if (idx == REG_STEREO) model_stereo = value[0];
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycles, msg);
  endtask

  // Sample source that favors the rails, zero and values near the held frame,
  // so that both large and small differences show up in the products.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      input logic signed [SAMPLE_BITS-1:0] near);
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return near + SAMPLE_BITS'($signed($urandom_range(64)) - 32);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Mostly moderate ratios around 1.0, with the zero step, tiny steps, heavy
  // downsampling and the largest step mixed in.
  function automatic logic [STEP_BITS-1:0] pick_step();
    case ($urandom_range(9))
      0: return '0;
      1: return STEP_BITS'($urandom_range(4095, 1));
      2: return STEP_TOP;
      3: return STEP_BITS'($urandom_range(32'h40000, 32'h14000));
      default: return STEP_BITS'($urandom_range(32'h14000, 32'h2000));
    endcase
  endfunction

  // Pop is redrawn every cycle from the current stall rate.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Output checker and cycle watchdog. Values are taken at the edge, before
  // the block updates them.
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d outputs pending", cycles,
               due_outputs.size());
      $display("linear_interp_resampler_test: errors");
      $finish;
    end
    if (!rst && pop && !empty) begin
      if (due_outputs.size() == 0) begin
        note_error($sformatf("unexpected output L=%0d R=%0d last=%0b",
                             out_left, out_right, last_of_run));
      end else begin
        want = due_outputs.pop_front();
        outputs_seen++;
        if (out_left !== want.left || out_right !== want.right ||
            last_of_run !== want.last) begin
          note_error($sformatf("output %0d: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                               outputs_seen, want.left, want.right, want.last,
                               out_left, out_right, last_of_run));
        end
      end
    end
  end

  // Reset state: step 1.0 and stereo. The first frame of a block only primes
  // the held frame, and each later frame gives one output equal to the
  // previous frame. Full-scale values in both directions are used.
  task automatic test_reset_defaults();
    send_frame(S_MAX, S_MIN, 1'b0);
    send_frame(S_MIN, S_MAX, 1'b0);
    send_frame('0, -24'sd1, 1'b0);
  endtask

  // Quarter and half steps between full-scale opposite frames. This covers the
  // largest products and the rounding ties in both directions.
  task automatic test_rounding();
    wait_idle();
    write_reg(REG_STEP, STEP_BITS'(32'h4000));
    send_frame(S_MAX, S_MIN, 1'b0);
    send_frame(S_MIN, S_MAX, 1'b0);
    wait_idle();
    write_reg(REG_STEP, STEP_BITS'(32'h8000));
    // A difference of +1 rounds up at the tie, and -1 rounds back to the
    // previous value.
    send_frame(S_MIN + 24'sd1, S_MAX - 24'sd1, 1'b0);
    send_frame(S_MIN + 24'sd4, S_MAX - 24'sd3, 1'b0);
  endtask

  // A step of 2.5 skips whole intervals, so some frames produce nothing.
  task automatic test_downsample();
    wait_idle();
    write_reg(REG_STEP, STEP_BITS'(32'h28000));
    repeat (4) send_frame(pick_sample(held_left), pick_sample(held_right), 1'b0);
  endtask

  // A zero step and a step of one LSB both stop at the output cap and skip the
  // rest of the interval. The largest step then drives the position far past
  // one unit.
  task automatic test_step_limits();
    wait_idle();
    write_reg(REG_STEP, '0);
    send_frame(24'sd1000, -24'sd1000, 1'b0);
    send_frame(S_MAX, S_MIN, 1'b0);
    wait_idle();
    write_reg(REG_STEP, STEP_BITS'(1));
    send_frame(S_MIN, S_MAX, 1'b0);
    wait_idle();
    write_reg(REG_STEP, STEP_TOP);
    send_frame(24'sd77, 24'sd99, 1'b0);
    send_frame(-24'sd5, 24'sd3, 1'b0);
  endtask

  // Mono clears the right output. Switching back to stereo between two frames
  // of one block uses the right sample that was stored while in mono.
  task automatic test_mono_switch();
    wait_idle();
    write_reg(REG_STEP, STEP_BITS'(32'hC000));
    write_reg(REG_STEREO, '0);
    send_frame(24'sd123456, S_MAX, 1'b0);
    send_frame(-24'sd654321, S_MIN, 1'b0);
    wait_idle();
    write_reg(REG_STEREO, STEP_BITS'(1));
    send_frame(24'sd42, 24'sd4242, 1'b0);
  endtask

  // Block end on a frame that produces outputs, then a one-frame block that
  // is stored and cleared straight away, then a fresh block.
  task automatic test_block_end();
    send_frame(S_MAX, S_MAX, 1'b1);
    send_frame(S_MIN, S_MIN, 1'b1);
    send_frame(24'sd10, -24'sd10, 1'b0);
    send_frame(-24'sd10, 24'sd10, 1'b0);
  endtask

  // Writes to indexes outside the map must leave step and stereo alone.
  task automatic test_spare_index();
    wait_idle();
    write_reg(REG_SPARE, '0);
    write_reg(REG_TOP, STEP_TOP);
    send_frame(24'sd300, -24'sd300, 1'b0);
    send_frame(24'sd301, -24'sd299, 1'b0);
  endtask

  // Random frames with the given pacing. The step and mode are redrawn every
  // FRAMES_PER_SETTING frames, each time after the block has drained. Blocks
  // are long on average, so most frames interpolate against a held frame.
  task automatic test_random_traffic(input int frames, input int idle_pct,
                                     input int stall_pct);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    for (int i = 0; i < frames; i++) begin
      if (i % FRAMES_PER_SETTING == 0) begin
        wait_idle();
        write_reg(REG_STEP, pick_step());
        write_reg(REG_STEREO, STEP_BITS'($urandom_range(1)));
      end
      send_frame(pick_sample(held_left), pick_sample(held_right),
                 ($urandom_range(15) == 0));
    end
  endtask

  initial begin
    errors = 0;
    frames_sent = 0;
    outputs_seen = 0;
    reg_writes = 0;
    cycles = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    model_step = STEP_RESET;
    model_stereo = 1'b1;
    held_left = '0;
    held_right = '0;
    read_pos = 0;
    holding = 1'b0;

    rst <= 1'b1;
    push <= 1'b0;
    sample_left <= '0;
    sample_right <= '0;
    block_end <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_rounding();
    test_downsample();
    test_step_limits();
    test_mono_switch();
    test_block_end();
    test_spare_index();

    // The four pacing mixes: free flow, a slow sender, a slow receiver, and
    // light stalls on both sides.
    test_random_traffic(96, 0, 0);
    test_random_traffic(96, 50, 0);
    test_random_traffic(96, 0, 50);
    test_random_traffic(96, 12, 12);

    wait_idle();
    if (due_outputs.size() != 0) begin
      note_error($sformatf("%0d expected outputs never arrived", due_outputs.size()));
    end

    $display("Sent %0d frames, checked %0d outputs, made %0d register writes.",
             frames_sent, outputs_seen, reg_writes);
    $display("Steps ran from zero to full scale in mono and stereo under four pacing mixes.");
    if (errors == 0) begin
      $display("linear_interp_resampler_test: clean");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("linear_interp_resampler_test: errors");
    end
    $finish;
  end

endmodule
